### hdl/htok_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request tokenizer package
// Shared record types, token kind codes and character constants.
// ----------------------------------------------------------------------------
package htok_pkg;

    // Widths of the result fields.
    localparam int OFS_W   = 11;
    localparam int IDX_W   = 7;
    localparam int COUNT_W = 8;
    localparam int KIND_W  = 3;

    // Token kind codes.
    localparam logic [KIND_W-1:0] KIND_METHOD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PATH    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NAME    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

    // Characters that steer the parse.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Output queue geometry. One request can produce two records, so the
    // input side is open only while two entries are free.
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = 2;
    localparam logic [OFIFO_AW:0] OFIFO_OPEN_LVL = 3'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [OFS_W-1:0]   token_start;
        logic [OFS_W-1:0]   token_length;
        logic [IDX_W-1:0]   header_index;
        logic [COUNT_W-1:0] header_count;
        logic               body_found;
        logic               too_many_headers;
        logic               last_result;
    } t_token_rec;

    // Records written into the output queue at the same time.
    typedef struct packed {
        logic [1:0] count;
        t_token_rec rec0;
        t_token_rec rec1;
    } t_fifo_wr;

endpackage

### hdl/htok_in_if.sv
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel that carries one request byte per transfer.
// ----------------------------------------------------------------------------
interface htok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/htok_out_if.sv
// ----------------------------------------------------------------------------
// Tokenizer output channel
// Valid/ready channel that carries one token record per transfer.
// ----------------------------------------------------------------------------
interface htok_out_if;
    logic                          valid;
    logic                          ready;
    logic [htok_pkg::KIND_W-1:0]   token_kind;
    logic [htok_pkg::OFS_W-1:0]    token_start;
    logic [htok_pkg::OFS_W-1:0]    token_length;
    logic [htok_pkg::IDX_W-1:0]    header_index;
    logic [htok_pkg::COUNT_W-1:0]  header_count;
    logic                          body_found;
    logic                          too_many_headers;
    logic                          last_result;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output header_index, output header_count, output body_found,
        output too_many_headers, output last_result, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input header_index, input header_count, input body_found,
        input too_many_headers, input last_result, output ready
    );
endinterface

### hdl/http_request_tokenizer.sv
// ----------------------------------------------------------------------------
// HTTP request tokenizer
// Splits an HTTP/1.x request, one byte per request on i_req, into token
// records (method, path, version, header names and values, end record).
// ----------------------------------------------------------------------------
// Usage: each request on i_req carries one byte of the HTTP message and a
// flag that marks the final byte of the message. Each token that closes
// yields one record on o_tok, and the final byte adds an end record with the
// body start, body length, body flag and header count.
// Throughput is one byte per cycle while i_req.ready is high: the parse
// state is updated in the cycle the byte is taken, by a single level of
// byte compares and offset adds. Records are written into the output queue
// at the accepting edge. A byte can produce two records (a token and the
// end record); those enter the four-entry output queue together and leave
// it one after the other. i_req.ready is high while the queue has room for
// two records, so a stalled receiver is absorbed until the queue holds
// three or more records, after which i_req is held off. No record is ever dropped.
// Reset (synchronous, active low) returns the parser to the method phase
// with all offsets and counts at zero and empties the output queue. The
// parser returns to the same state by itself after every final byte.
// ----------------------------------------------------------------------------
module http_request_tokenizer #(
    parameter int MAX_BYTES          = 1024,
    parameter int MAX_HEADER_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    htok_in_if.sink     i_req,
    htok_out_if.source  o_tok
);

    // Offsets reach MAX_BYTES + 2 inside length arithmetic.
    localparam int POS_W  = $clog2(MAX_BYTES + 3);
    localparam int HDR_W  = $clog2(MAX_HEADER_ENTRIES + 1);
    localparam int CALC_W = (POS_W > htok_pkg::OFS_W) ? POS_W : htok_pkg::OFS_W;
    localparam int CNT_W  = (HDR_W > htok_pkg::COUNT_W) ? HDR_W : htok_pkg::COUNT_W;
    localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(MAX_BYTES);
    localparam logic [HDR_W-1:0] LIMIT_HDR = HDR_W'(MAX_HEADER_ENTRIES);

    // Parse phases.
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_PATH    = 4'd1;
    localparam logic [3:0] PH_PREVER  = 4'd2;
    localparam logic [3:0] PH_VERSION = 4'd3;
    localparam logic [3:0] PH_NAME    = 4'd4;
    localparam logic [3:0] PH_VALUE   = 4'd5;
    localparam logic [3:0] PH_BODY    = 4'd6;
    localparam logic [3:0] PH_LOOK    = 4'd7;
    localparam logic [3:0] PH_SKIP    = 4'd8;

    function automatic logic [CALC_W-1:0] f_sat_sub(input logic [CALC_W-1:0] a,
                                                    input logic [CALC_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

    // Parser state.
    logic [3:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [POS_W-1:0] r_tbeg,  n_tbeg;
    logic [HDR_W-1:0] r_hdrs,  n_hdrs;
    logic             r_ovf,   n_ovf;

    logic                          w_take;
    logic [7:0]                    w_byte;
    logic                          w_open;
    logic                          w_tok_valid;
    logic [htok_pkg::KIND_W-1:0]   w_tok_kind;
    logic [CALC_W-1:0]             w_tok_start;
    logic [CALC_W-1:0]             w_tok_len;
    logic [HDR_W-1:0]              w_slot;
    logic [CNT_W-1:0]              w_count;
    logic [CALC_W-1:0]             w_pos_c;
    logic [CALC_W-1:0]             w_tbeg_c;
    logic [CALC_W-1:0]             w_npos_c;
    logic [CALC_W-1:0]             w_ntbeg_c;
    logic [CALC_W-1:0]             w_end_len;
    htok_pkg::t_token_rec          w_tok_rec;
    htok_pkg::t_token_rec          w_end_rec;
    htok_pkg::t_fifo_wr            w_wr;
    logic [htok_pkg::OFIFO_AW:0]   w_level;

    assign w_take      = i_req.valid && i_req.ready;
    assign w_byte      = i_req.data_byte;
    assign i_req.ready = (w_level <= htok_pkg::OFIFO_OPEN_LVL);

    assign w_pos_c  = CALC_W'(r_pos);
    assign w_tbeg_c = CALC_W'(r_tbeg);

    // One byte step: phase decode, token close and header slot update.
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_tbeg      = r_tbeg;
        n_hdrs      = r_hdrs;
        n_ovf       = r_ovf;
        w_open      = 1'b0;
        w_tok_valid = 1'b0;
        w_tok_kind  = htok_pkg::KIND_METHOD;
        w_tok_start = w_tbeg_c;
        w_tok_len   = '0;

        // Bytes past the buffer limit are not parsed; the position sticks.
        if (r_pos < LIMIT_POS) begin
            n_pos = r_pos + 1'b1;
            unique case (r_phase)
                PH_METHOD: begin
                    if (w_byte == htok_pkg::CH_SP) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = htok_pkg::KIND_METHOD;
                        w_tok_len   = f_sat_sub(w_pos_c, w_tbeg_c);
                        n_tbeg      = r_pos + 1'b1;
                        n_phase     = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (w_byte == htok_pkg::CH_SP) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = htok_pkg::KIND_PATH;
                        w_tok_len   = f_sat_sub(w_pos_c, w_tbeg_c);
                        n_phase     = PH_PREVER;
                    end
                end
                PH_PREVER: begin
                    // The version token starts after the slash of "HTTP/".
                    if (w_byte == htok_pkg::CH_SLASH) begin
                        n_tbeg  = r_pos + 1'b1;
                        n_phase = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    // The length drops the CR in front of the LF.
                    if (w_byte == htok_pkg::CH_LF) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = htok_pkg::KIND_VERSION;
                        w_tok_len   = f_sat_sub(w_pos_c, w_tbeg_c + 1'b1);
                        n_tbeg      = r_pos + 1'b1;
                        w_open      = 1'b1;
                        n_phase     = PH_NAME;
                    end
                end
                PH_NAME: begin
                    // The value is taken to begin two bytes after the colon.
                    if (w_byte == htok_pkg::CH_COLON) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = htok_pkg::KIND_NAME;
                        w_tok_len   = f_sat_sub(w_pos_c, w_tbeg_c);
                        n_tbeg      = r_pos + POS_W'(2);
                        n_phase     = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (w_byte == htok_pkg::CH_LF) begin
                        w_tok_valid = 1'b1;
                        w_tok_kind  = htok_pkg::KIND_VALUE;
                        w_tok_len   = f_sat_sub(w_pos_c, w_tbeg_c + 1'b1);
                        n_tbeg      = r_pos + 1'b1;
                        n_phase     = PH_LOOK;
                    end
                end
                PH_LOOK: begin
                    // Byte after a header line: blank line, or a new header
                    // whose first byte is parsed as a name byte right away.
                    if (w_byte == htok_pkg::CH_CR) begin
                        n_tbeg  = r_pos + POS_W'(2);
                        n_phase = PH_SKIP;
                    end else if (w_byte == htok_pkg::CH_LF) begin
                        n_tbeg  = r_pos + 1'b1;
                        n_phase = PH_BODY;
                    end else begin
                        w_open = 1'b1;
                        if (w_byte == htok_pkg::CH_COLON) begin
                            w_tok_valid = 1'b1;
                            w_tok_kind  = htok_pkg::KIND_NAME;
                            w_tok_start = w_pos_c;
                            w_tok_len   = '0;
                            n_tbeg      = r_pos + POS_W'(2);
                            n_phase     = PH_VALUE;
                        end else begin
                            n_tbeg  = r_pos;
                            n_phase = PH_NAME;
                        end
                    end
                end
                default: begin
                    // The skipped LF, the body, and unused codes all land here.
                    n_phase = PH_BODY;
                end
            endcase
        end

        // Open a header slot, or flag overflow once the table is full.
        if (w_open) begin
            if (r_hdrs < LIMIT_HDR) begin
                n_hdrs = r_hdrs + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign w_slot    = (n_hdrs != '0) ? (n_hdrs - 1'b1) : '0;
    assign w_count   = CNT_W'(n_hdrs);
    assign w_npos_c  = CALC_W'(n_pos);
    assign w_ntbeg_c = CALC_W'(n_tbeg);
    assign w_end_len = f_sat_sub(w_npos_c, w_ntbeg_c);

    // Token record. The version record reports the overflow flag from before
    // its own header slot opens; a name closed on the lookahead byte sees
    // the updated flag and slot.
    always_comb begin
        w_tok_rec.token_kind       = w_tok_kind;
        w_tok_rec.token_start      = w_tok_start[htok_pkg::OFS_W-1:0];
        w_tok_rec.token_length     = w_tok_len[htok_pkg::OFS_W-1:0];
        w_tok_rec.header_index     = '0;
        if ((w_tok_kind == htok_pkg::KIND_NAME) || (w_tok_kind == htok_pkg::KIND_VALUE)) begin
            w_tok_rec.header_index = htok_pkg::IDX_W'(w_slot);
        end
        w_tok_rec.header_count     = '0;
        w_tok_rec.body_found       = 1'b0;
        w_tok_rec.too_many_headers = (r_phase == PH_VERSION) ? r_ovf : n_ovf;
        w_tok_rec.last_result      = 1'b0;
    end

    // End record, built from the state after this byte.
    always_comb begin
        w_end_rec.token_kind       = htok_pkg::KIND_END;
        w_end_rec.token_start      = w_ntbeg_c[htok_pkg::OFS_W-1:0];
        w_end_rec.token_length     = w_end_len[htok_pkg::OFS_W-1:0];
        w_end_rec.header_index     = '0;
        w_end_rec.header_count     = w_count[htok_pkg::COUNT_W-1:0];
        w_end_rec.body_found       = (n_phase == PH_BODY) || (n_phase == PH_SKIP);
        w_end_rec.too_many_headers = n_ovf;
        w_end_rec.last_result      = 1'b1;
    end

    // Queue write: the token record goes first, the end record after it.
    always_comb begin
        w_wr.count = '0;
        if (w_take) begin
            w_wr.count = {1'b0, w_tok_valid} + {1'b0, i_req.last_byte};
        end
        w_wr.rec0 = w_tok_valid ? w_tok_rec : w_end_rec;
        w_wr.rec1 = w_end_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_pos   <= '0;
            r_tbeg  <= '0;
            r_hdrs  <= '0;
            r_ovf   <= 1'b0;
        end else if (w_take) begin
            if (i_req.last_byte) begin
                r_phase <= PH_METHOD;
                r_pos   <= '0;
                r_tbeg  <= '0;
                r_hdrs  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_tbeg  <= n_tbeg;
                r_hdrs  <= n_hdrs;
                r_ovf   <= n_ovf;
            end
        end
    end

    htok_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_level (w_level),
        .o_tok   (o_tok)
    );

endmodule

### hdl/htok_out_fifo.sv
// ----------------------------------------------------------------------------
// Tokenizer output queue
// Small queue that takes up to two records per cycle and sends one on ready.
// ----------------------------------------------------------------------------
module htok_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htok_pkg::t_fifo_wr            i_wr,
    output logic [htok_pkg::OFIFO_AW:0]   o_level,
    htok_out_if.source                    o_tok
);

    htok_pkg::t_token_rec                r_mem [htok_pkg::OFIFO_DEPTH];
    logic [htok_pkg::OFIFO_AW-1:0]       r_wptr;
    logic [htok_pkg::OFIFO_AW-1:0]       r_rptr;
    logic [htok_pkg::OFIFO_AW:0]         r_level;
    logic                                w_pop;
    htok_pkg::t_token_rec                w_head;

    assign w_pop = o_tok.valid && o_tok.ready;

    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_wptr] <= i_wr.rec0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[r_wptr + 1'b1] <= i_wr.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + htok_pkg::OFIFO_AW'(i_wr.count);
            r_rptr  <= r_rptr + htok_pkg::OFIFO_AW'(w_pop);
            r_level <= r_level + (htok_pkg::OFIFO_AW + 1)'(i_wr.count)
                       - (htok_pkg::OFIFO_AW + 1)'(w_pop);
        end
    end

    assign w_head  = r_mem[r_rptr];
    assign o_level = r_level;

    assign o_tok.valid            = (r_level != '0);
    assign o_tok.token_kind       = w_head.token_kind;
    assign o_tok.token_start      = w_head.token_start;
    assign o_tok.token_length     = w_head.token_length;
    assign o_tok.header_index     = w_head.header_index;
    assign o_tok.header_count     = w_head.header_count;
    assign o_tok.body_found       = w_head.body_found;
    assign o_tok.too_many_headers = w_head.too_many_headers;
    assign o_tok.last_result      = w_head.last_result;

endmodule

### verif/htok_record_check.sv
// ----------------------------------------------------------------------------
// Tokenizer record checker
// Watches both channels of the tokenizer, predicts the token records of every
// accepted request and compares each accepted record with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module htok_record_check #(
    parameter int BYTE_LIMIT = 1024,
    parameter int SLOT_LIMIT = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    htok_in_if   i_req,
    htok_out_if  i_tok,
    output int   o_err_count,
    output int   o_pending
);

    typedef enum logic [3:0] {
        SCAN_METHOD, SCAN_PATH, SCAN_GAP, SCAN_VERSION, SCAN_NAME,
        SCAN_VALUE, SCAN_BODY, SCAN_PEEK, SCAN_SKIP
    } t_scan_phase;

    t_scan_phase scan_phase;
    int unsigned cur_pos;
    int unsigned tok_start;
    int unsigned hdr_slots;
    logic        hdr_overflow;
    int          err_total;

    htok_pkg::t_token_rec expected_tokens[$];

    function automatic int unsigned clamp_diff(int unsigned a, int unsigned b);
        return (a >= b) ? a - b : 0;
    endfunction

    function automatic int unsigned cur_slot();
        return (hdr_slots > 0) ? hdr_slots - 1 : 0;
    endfunction

    function automatic string rec_text(htok_pkg::t_token_rec r);
        return $sformatf("kind=%0d start=%0d len=%0d idx=%0d count=%0d body=%0b ovf=%0b last=%0b",
                         r.token_kind, r.token_start, r.token_length, r.header_index,
                         r.header_count, r.body_found, r.too_many_headers, r.last_result);
    endfunction

    task automatic clear_state();
        scan_phase   = SCAN_METHOD;
        cur_pos      = 0;
        tok_start    = 0;
        hdr_slots    = 0;
        hdr_overflow = 1'b0;
    endtask

    task automatic push_record(input logic [htok_pkg::KIND_W-1:0] kind,
                               input int unsigned start,
                               input int unsigned len, input int unsigned idx,
                               input int unsigned count, input logic body,
                               input logic last);
        htok_pkg::t_token_rec rec;
        rec.token_kind       = kind;
        rec.token_start      = start[htok_pkg::OFS_W-1:0];
        rec.token_length     = len[htok_pkg::OFS_W-1:0];
        rec.header_index     = idx[htok_pkg::IDX_W-1:0];
        rec.header_count     = count[htok_pkg::COUNT_W-1:0];
        rec.body_found       = body;
        rec.too_many_headers = hdr_overflow;
        rec.last_result      = last;
        expected_tokens.push_back(rec);
    endtask

    task automatic open_slot();
        if (hdr_slots < SLOT_LIMIT) begin
            hdr_slots++;
        end else begin
            hdr_overflow = 1'b1;
        end
    endtask

    // A colon closes the name; the value is taken to start two bytes later.
    task automatic name_char(input logic [7:0] b, input int unsigned i);
        if (b == htok_pkg::CH_COLON) begin
            push_record(htok_pkg::KIND_NAME, tok_start, clamp_diff(i, tok_start), cur_slot(),
                        0, 1'b0, 1'b0);
            tok_start  = i + 2;
            scan_phase = SCAN_VALUE;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] b, input logic is_last);
        int unsigned i;
        logic        found;
        i = cur_pos;
        if (i < BYTE_LIMIT) begin
            case (scan_phase)
                SCAN_METHOD: begin
                    if (b == htok_pkg::CH_SP) begin
                        push_record(htok_pkg::KIND_METHOD, tok_start,
                                    clamp_diff(i, tok_start), 0, 0, 1'b0, 1'b0);
                        tok_start  = i + 1;
                        scan_phase = SCAN_PATH;
                    end
                end
                SCAN_PATH: begin
                    if (b == htok_pkg::CH_SP) begin
                        push_record(htok_pkg::KIND_PATH, tok_start,
                                    clamp_diff(i, tok_start), 0, 0, 1'b0, 1'b0);
                        scan_phase = SCAN_GAP;
                    end
                end
                SCAN_GAP: begin
                    if (b == htok_pkg::CH_SLASH) begin
                        tok_start  = i + 1;
                        scan_phase = SCAN_VERSION;
                    end
                end
                SCAN_VERSION: begin
                    if (b == htok_pkg::CH_LF) begin
                        push_record(htok_pkg::KIND_VERSION, tok_start,
                                    clamp_diff(i, tok_start + 1), 0, 0, 1'b0, 1'b0);
                        tok_start = i + 1;
                        open_slot();
                        scan_phase = SCAN_NAME;
                    end
                end
                SCAN_NAME: begin
                    name_char(b, i);
                end
                SCAN_VALUE: begin
                    if (b == htok_pkg::CH_LF) begin
                        push_record(htok_pkg::KIND_VALUE, tok_start,
                                    clamp_diff(i, tok_start + 1), cur_slot(), 0,
                                    1'b0, 1'b0);
                        tok_start  = i + 1;
                        scan_phase = SCAN_PEEK;
                    end
                end
                SCAN_PEEK: begin
                    // The byte after a header line decides between another
                    // header and the start of the body.
                    if (b == htok_pkg::CH_CR) begin
                        tok_start  = i + 2;
                        scan_phase = SCAN_SKIP;
                    end else if (b == htok_pkg::CH_LF) begin
                        tok_start  = i + 1;
                        scan_phase = SCAN_BODY;
                    end else begin
                        tok_start = i;
                        open_slot();
                        scan_phase = SCAN_NAME;
                        name_char(b, i);
                    end
                end
                default: begin
                    scan_phase = SCAN_BODY;
                end
            endcase
            cur_pos = i + 1;
        end
        if (is_last) begin
            found = (scan_phase == SCAN_BODY) || (scan_phase == SCAN_SKIP);
            push_record(htok_pkg::KIND_END, tok_start, clamp_diff(cur_pos, tok_start), 0,
                        hdr_slots, found, 1'b1);
            clear_state();
        end
    endtask

    always @(posedge i_clk) begin
        htok_pkg::t_token_rec got;
        htok_pkg::t_token_rec want;
        if (!i_rst_n) begin
            clear_state();
            expected_tokens.delete();
        end else begin
            // Records leaving now were caused by earlier requests, so the
            // comparison comes before this edge's request is predicted.
            if (i_tok.valid && i_tok.ready) begin
                got.token_kind       = i_tok.token_kind;
                got.token_start      = i_tok.token_start;
                got.token_length     = i_tok.token_length;
                got.header_index     = i_tok.header_index;
                got.header_count     = i_tok.header_count;
                got.body_found       = i_tok.body_found;
                got.too_many_headers = i_tok.too_many_headers;
                got.last_result      = i_tok.last_result;
                if (expected_tokens.size() == 0) begin
                    $display("%0t: record with none due: expected nothing, actual %s",
                             $time, rec_text(got));
                    err_total++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        $display("%0t: wrong record: expected %s, actual %s",
                                 $time, rec_text(want), rec_text(got));
                        err_total++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                tokenize_byte(i_req.data_byte, i_req.last_byte);
            end
        end
        o_err_count <= err_total;
        o_pending   <= expected_tokens.size();
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// HTTP request tokenizer testbench
// Feeds short directed messages, then random well-formed, cut-off and noisy
// HTTP messages through the tokenizer under three idle patterns, while a
// checker beside the block compares every token record with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int BYTE_LIMIT   = 1024;
    localparam int SLOT_LIMIT   = 128;
    // Cycles in a row with no request and no record accepted before the run
    // is given up. Random stalls on both sides never come near this.
    localparam int STALL_LIMIT  = 2000;
    // Message bytes to send, at least, in each of the three idle patterns.
    localparam int PHASE_BYTES  = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Everything the block sees starts at a known value at time zero.
    logic       tx_valid = 1'b0;
    logic [7:0] tx_byte  = 8'h00;
    logic       tx_last  = 1'b0;
    logic       rx_ready = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int err_count;
    int pending_count;
    int idle_run;

    // Bytes of the HTTP message that is about to be sent.
    logic [7:0] msg[$];

    htok_in_if  req_if ();
    htok_out_if tok_if ();

    assign req_if.valid     = tx_valid;
    assign req_if.data_byte = tx_byte;
    assign req_if.last_byte = tx_last;
    assign tok_if.ready     = rx_ready;

    always #4 clk = ~clk;

    http_request_tokenizer #(
        .MAX_BYTES          (BYTE_LIMIT),
        .MAX_HEADER_ENTRIES (SLOT_LIMIT)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_tok   (tok_if)
    );

    htok_record_check #(
        .BYTE_LIMIT (BYTE_LIMIT),
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .i_tok       (tok_if),
        .o_err_count (err_count),
        .o_pending   (pending_count)
    );

    // The receiver stalls at random; held low while reset is asserted.
    always @(posedge clk) begin
        rx_ready <= rst_n ? ($urandom_range(0, 99) >= rx_idle_pct) : 1'b0;
    end

    // Appends len random bytes, none of which equals one of the three bytes
    // given. Most are letters, which never steer the parse, and the rest are
    // drawn from the whole byte range so that high bytes show up as well.
    task automatic add_text(input int len, input logic [7:0] bad_a,
                            input logic [7:0] bad_b, input logic [7:0] bad_c);
        logic [7:0] c;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                c = 8'h41 + 8'($urandom_range(0, 25));
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (c == bad_a || c == bad_b || c == bad_c);
            end
            msg.push_back(c);
        end
    endtask

    // Builds a well-formed message with random content: request line,
    // n_hdr header lines whose name and value run up to text_max bytes, a
    // blank line and a body. CR before LF is left out now and then. About
    // one message in five is cut short at a random byte, so that the final
    // byte lands in every phase of the parse.
    task automatic build_request(input int n_hdr, input int n_body, input int text_max);
        int cut;
        add_text($urandom_range(0, 6), htok_pkg::CH_SP, htok_pkg::CH_SP, htok_pkg::CH_SP);
        msg.push_back(htok_pkg::CH_SP);
        msg.push_back(htok_pkg::CH_SLASH);
        add_text($urandom_range(0, 8), htok_pkg::CH_SP, htok_pkg::CH_SP, htok_pkg::CH_SP);
        msg.push_back(htok_pkg::CH_SP);
        add_text($urandom_range(0, 4), htok_pkg::CH_SLASH, htok_pkg::CH_SLASH,
                 htok_pkg::CH_SLASH);
        msg.push_back(htok_pkg::CH_SLASH);
        add_text($urandom_range(0, 3), htok_pkg::CH_LF, htok_pkg::CH_LF, htok_pkg::CH_LF);
        if ($urandom_range(0, 4) != 0) msg.push_back(htok_pkg::CH_CR);
        msg.push_back(htok_pkg::CH_LF);
        for (int h = 0; h < n_hdr; h++) begin
            // A name must not open with CR or LF, or it reads as the blank line.
            add_text($urandom_range(0, text_max), htok_pkg::CH_COLON, htok_pkg::CH_CR,
                     htok_pkg::CH_LF);
            msg.push_back(htok_pkg::CH_COLON);
            if ($urandom_range(0, 3) != 0) msg.push_back(htok_pkg::CH_SP);
            add_text($urandom_range(0, text_max), htok_pkg::CH_LF, htok_pkg::CH_LF,
                     htok_pkg::CH_LF);
            if ($urandom_range(0, 4) != 0) msg.push_back(htok_pkg::CH_CR);
            msg.push_back(htok_pkg::CH_LF);
        end
        if ($urandom_range(0, 4) != 0) msg.push_back(htok_pkg::CH_CR);
        msg.push_back(htok_pkg::CH_LF);
        for (int k = 0; k < n_body; k++) begin
            msg.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut) void'(msg.pop_back());
        end
    endtask

    // Sends the message one request per byte, the final byte flagged, with
    // random gaps before requests. The valid line is only lowered when a gap
    // follows, so it is never lowered and raised in the same step.
    task automatic send_msg();
        for (int k = 0; k < msg.size(); k++) begin
            if ($urandom_range(0, 99) < tx_idle_pct) begin
                tx_valid <= 1'b0;
                do begin
                    @(posedge clk);
                end while ($urandom_range(0, 99) < tx_idle_pct);
            end
            tx_valid <= 1'b1;
            tx_byte  <= msg[k];
            tx_last  <= (k == msg.size() - 1);
            @(posedge clk);
            while (!req_if.ready) @(posedge clk);
        end
        msg.delete();
    endtask

    initial begin : stimulus
        int sent;
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone high byte flagged as final: end record from the method phase.
        msg = '{8'hFF};
        send_msg();
        // A lone space: an empty method and the end record from one byte.
        msg = '{htok_pkg::CH_SP};
        send_msg();
        // A complete message with an LF-only blank line and a one-byte body.
        // The empty value gives a length that saturates; the version is empty.
        msg = '{8'h41, htok_pkg::CH_SP, htok_pkg::CH_SLASH, htok_pkg::CH_SP,
                htok_pkg::CH_SLASH, htok_pkg::CH_CR, htok_pkg::CH_LF,
                htok_pkg::CH_COLON, htok_pkg::CH_CR, htok_pkg::CH_LF, htok_pkg::CH_LF,
                8'h80};
        send_msg();
        // A message that ends on the CR of the blank line.
        msg = '{htok_pkg::CH_SP, 8'h78, htok_pkg::CH_SP, htok_pkg::CH_SLASH,
                htok_pkg::CH_LF, htok_pkg::CH_COLON, htok_pkg::CH_LF, htok_pkg::CH_CR};
        send_msg();
        // A message that ends on a header LF, before the lookahead byte.
        msg = '{htok_pkg::CH_SP, htok_pkg::CH_SP, htok_pkg::CH_SLASH, htok_pkg::CH_LF,
                htok_pkg::CH_COLON, htok_pkg::CH_LF};
        send_msg();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 13;
                    rx_idle_pct <= 54;
                end
                1: begin
                    tx_idle_pct  = 54;
                    rx_idle_pct <= 13;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_idle_pct <= 0;
                end
            endcase

            // One large message under the first pattern: more headers than
            // the table holds, then a body that can run past the byte limit.
            if (ph == 0) begin
                build_request(SLOT_LIMIT + 3, BYTE_LIMIT - 440, 0);
                send_msg();
            end

            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    build_request($urandom_range(0, 4), $urandom_range(0, 10), 6);
                end else begin
                    // Noise: at least half the bytes are ones that steer the parse.
                    r = $urandom_range(1, 16);
                    for (int k = 0; k < r; k++) begin
                        case ($urandom_range(0, 9))
                            0: msg.push_back(htok_pkg::CH_SP);
                            1: msg.push_back(htok_pkg::CH_SLASH);
                            2: msg.push_back(htok_pkg::CH_COLON);
                            3: msg.push_back(htok_pkg::CH_CR);
                            4: msg.push_back(htok_pkg::CH_LF);
                            default: msg.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                sent += msg.size();
                send_msg();
            end
        end

        tx_valid <= 1'b0;
        // The checker's counts are registered and trail the edge that they describe.
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0 && pending_count == 0) begin
            $display("http_request_tokenizer: match");
        end else begin
            $display("http_request_tokenizer: mismatch");
        end
        $finish;
    end

    // Watchdog: gives up when neither channel has moved for too long.
    initial begin : watchdog
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if (rst_n && !(req_if.valid && req_if.ready) && !(tok_if.valid && tok_if.ready)) begin
                idle_run++;
            end else begin
                idle_run = 0;
            end
        end
        $display("http_request_tokenizer: mismatch");
        $finish;
    end

endmodule
